// ===== src/dwsp_pkg.sv =====
// Shared types, codes and constants of the dual wheel speed PID block.
package dwsp_pkg;

  // Field and datapath widths
  localparam int unsigned CountW  = 16;
  localparam int unsigned WordW   = 32;
  localparam int unsigned ErrW    = 33;
  localparam int unsigned DerivW  = 34;
  localparam int unsigned WideW   = 48;
  localparam int unsigned ChunkW  = 16;
  localparam int unsigned ProdW   = WordW + ChunkW + 1;
  localparam int unsigned AccW    = 84;
  localparam int unsigned LimW    = 31;
  localparam int unsigned CmpW    = 16;
  localparam int unsigned DirW    = 2;
  localparam int unsigned CfgIdxW = 3;

  // Register reset values
  localparam logic [LimW-1:0]   OutLimitRst   = 31'd65536;
  localparam logic [ChunkW-1:0] SpeedScaleRst = 16'd745;
  localparam logic [ChunkW-1:0] PwmPeriodRst  = 16'd7200;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_GOAL_LEFT   = 3'd0,
    CFG_GOAL_RIGHT  = 3'd1,
    CFG_GAIN_P      = 3'd2,
    CFG_GAIN_I      = 3'd3,
    CFG_GAIN_D      = 3'd4,
    CFG_OUT_LIMIT   = 3'd5,
    CFG_SPEED_SCALE = 3'd6,
    CFG_PWM_PERIOD  = 3'd7
  } cfg_reg_e;

  // Drive direction codes
  typedef enum logic [DirW-1:0] {
    DIR_BRAKE = 2'd0,
    DIR_FWD   = 2'd1,
    DIR_REV   = 2'd2
  } dir_e;

  // Operand pair fed to the shared multiplier
  typedef enum logic [2:0] {
    MUL_SPEED = 3'd0,
    MUL_P     = 3'd1,
    MUL_I     = 3'd2,
    MUL_D     = 3'd3,
    MUL_PWM   = 3'd4
  } mul_sel_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_SPEED = 4'd1,
    ST_ERR   = 4'd2,
    ST_UPD   = 4'd3,
    ST_MAC   = 4'd4,
    ST_DRAIN = 4'd5,
    ST_CLAMP = 4'd6,
    ST_PWM   = 4'd7,
    ST_CMP   = 4'd8,
    ST_DONE  = 4'd9
  } state_e;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic      load_in;
    logic      wheel;
    logic      mul_en;
    mul_sel_e  mul_sel;
    logic [1:0] mul_chunk;
    logic      acc_clr;
    logic      acc_add;
    logic      err_en;
    logic      upd_en;
    logic      clamp_en;
    logic      cmp_en;
    logic      done_en;
  } dwsp_cmd_t;

endpackage

// ===== src/dwsp_ctrl.sv =====
// Sequencer: steps each wheel through speed, error, MAC, clamp and PWM scaling.
module dwsp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output dwsp_pkg::dwsp_cmd_t  cmd_o
);
  import dwsp_pkg::*;

  state_e     state_q, state_d;
  logic       wheel_q, wheel_d;
  logic [1:0] term_q, term_d;
  logic [1:0] chunk_q, chunk_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Next state
  always_comb begin
    state_d     = state_q;
    wheel_d     = wheel_q;
    term_d      = term_q;
    chunk_d     = chunk_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SPEED;
          wheel_d = 1'b0;
        end
      end
      ST_SPEED: state_d = ST_ERR;
      ST_ERR:   state_d = ST_UPD;
      ST_UPD: begin
        state_d = ST_MAC;
        term_d  = 2'd0;
        chunk_d = 2'd0;
      end
      ST_MAC: begin
        if (chunk_q == 2'd2) begin
          chunk_d = 2'd0;
          term_d  = term_q + 2'd1;
          if (term_q == 2'd2) begin
            state_d = ST_DRAIN;
          end
        end else begin
          chunk_d = chunk_q + 2'd1;
        end
      end
      ST_DRAIN: state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_PWM;
      ST_PWM:   state_d = ST_CMP;
      ST_CMP: begin
        if (wheel_q) begin
          state_d = ST_DONE;
        end else begin
          wheel_d = 1'b1;
          state_d = ST_SPEED;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          wheel_d     = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.wheel     = wheel_q;
    cmd_o.mul_sel   = MUL_SPEED;
    cmd_o.mul_chunk = 2'd0;
    in_ready_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_SPEED: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_SPEED;
      end
      ST_ERR: cmd_o.err_en = 1'b1;
      ST_UPD: cmd_o.upd_en = 1'b1;
      ST_MAC: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_chunk = chunk_q;
        unique case (term_q)
          2'd1:    cmd_o.mul_sel = MUL_I;
          2'd2:    cmd_o.mul_sel = MUL_D;
          default: cmd_o.mul_sel = MUL_P;
        endcase
        // first product is still in flight: clear, later ones add
        if (term_q == 2'd0 && chunk_q == 2'd0) begin
          cmd_o.acc_clr = 1'b1;
        end else begin
          cmd_o.acc_add = 1'b1;
        end
      end
      ST_DRAIN: cmd_o.acc_add  = 1'b1;
      ST_CLAMP: cmd_o.clamp_en = 1'b1;
      ST_PWM: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_PWM;
      end
      ST_CMP:  cmd_o.cmp_en  = 1'b1;
      ST_DONE: cmd_o.done_en = slot_free;
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wheel_q     <= 1'b0;
      term_q      <= 2'd0;
      chunk_q     <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wheel_q     <= wheel_d;
      term_q      <= term_d;
      chunk_q     <= chunk_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/dwsp_datapath.sv =====
// Datapath: config registers, wheel state, shared multiplier and accumulator.
module dwsp_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dwsp_pkg::dwsp_cmd_t         cmd_i,
  input  logic                        cfg_valid_i,
  input  logic [dwsp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dwsp_pkg::WordW-1:0]  cfg_data_i,
  input  logic signed [15:0]          count_left_i,
  input  logic signed [15:0]          count_right_i,
  output logic [1:0]                  dir_left_o,
  output logic [15:0]                 compare_left_o,
  output logic [1:0]                  dir_right_o,
  output logic [15:0]                 compare_right_o,
  output logic signed [47:0]          odometry_o
);
  import dwsp_pkg::*;

  localparam logic [WideW-1:0] Max48 = {1'b0, {(WideW-1){1'b1}}};
  localparam logic [WideW-1:0] Min48 = {1'b1, {(WideW-1){1'b0}}};

  // Saturate a 49-bit sum to 48 bits
  function automatic logic [WideW-1:0] sat48(input logic [WideW:0] v);
    logic [WideW-1:0] r;
    if (v[WideW] != v[WideW-1]) begin
      r = v[WideW] ? Min48 : Max48;
    end else begin
      r = v[WideW-1:0];
    end
    return r;
  endfunction

  // Configuration registers
  logic [WordW-1:0]  goal_l_q, goal_r_q, gain_p_q, gain_i_q, gain_d_q;
  logic [LimW-1:0]   out_limit_q;
  logic [ChunkW-1:0] speed_scale_q, pwm_period_q;

  // Per-item and per-wheel registers
  logic [CountW-1:0] cnt_l_q, cnt_r_q;
  logic [ProdW-1:0]  prod_q;
  logic [1:0]        prod_shift_q;
  logic [AccW-1:0]   acc_q;
  logic [ErrW-1:0]   err_q;
  logic [DerivW-1:0] deriv_q;
  logic [WideW-1:0]  integ_q [2];
  logic [ErrW-1:0]   prior_q [2];
  logic [WideW-1:0]  dist_q;
  logic [LimW-1:0]   mag_q;
  logic [DirW-1:0]   dir_w_q [2];
  logic [CmpW-1:0]   cmp_w_q [2];
  logic [DirW-1:0]   dir_l_out_q, dir_r_out_q;
  logic [CmpW-1:0]   cmp_l_out_q, cmp_r_out_q;

  // Wheel selection
  logic              w;
  logic [CountW-1:0] cnt_w;
  logic [WordW-1:0]  goal_w;

  assign w      = cmd_i.wheel;
  assign cnt_w  = w ? cnt_r_q : cnt_l_q;
  assign goal_w = w ? goal_r_q : goal_l_q;

  // Config write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_l_q      <= '0;
      goal_r_q      <= '0;
      gain_p_q      <= '0;
      gain_i_q      <= '0;
      gain_d_q      <= '0;
      out_limit_q   <= OutLimitRst;
      speed_scale_q <= SpeedScaleRst;
      pwm_period_q  <= PwmPeriodRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_GOAL_LEFT:   goal_l_q      <= cfg_data_i;
        CFG_GOAL_RIGHT:  goal_r_q      <= cfg_data_i;
        CFG_GAIN_P:      gain_p_q      <= cfg_data_i;
        CFG_GAIN_I:      gain_i_q      <= cfg_data_i;
        CFG_GAIN_D:      gain_d_q      <= cfg_data_i;
        CFG_OUT_LIMIT:   out_limit_q   <= cfg_data_i[LimW-1:0];
        CFG_SPEED_SCALE: speed_scale_q <= cfg_data_i[ChunkW-1:0];
        CFG_PWM_PERIOD:  pwm_period_q  <= cfg_data_i[ChunkW-1:0];
      endcase
    end
  end

  // Shared multiplier: 32-bit signed operand times one 16-bit slice
  logic [WordW-1:0]         op_a;
  logic [WideW-1:0]         op_b;
  logic [ChunkW:0]          chunk;
  logic signed [ProdW-1:0]  prod_d;

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_SPEED: begin
        op_a = {{(WordW-CountW){cnt_w[CountW-1]}}, cnt_w};
        op_b = {{(WideW-ChunkW){1'b0}}, speed_scale_q};
      end
      MUL_P: begin
        op_a = gain_p_q;
        op_b = {{(WideW-ErrW){err_q[ErrW-1]}}, err_q};
      end
      MUL_I: begin
        op_a = gain_i_q;
        op_b = integ_q[w];
      end
      MUL_D: begin
        op_a = gain_d_q;
        op_b = {{(WideW-DerivW){deriv_q[DerivW-1]}}, deriv_q};
      end
      MUL_PWM: begin
        op_a = {1'b0, mag_q};
        op_b = {{(WideW-ChunkW){1'b0}}, pwm_period_q};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    // low slices unsigned, top slice carries the sign
    unique case (cmd_i.mul_chunk)
      2'd0:    chunk = {1'b0, op_b[15:0]};
      2'd1:    chunk = {1'b0, op_b[31:16]};
      default: chunk = {op_b[47], op_b[47:32]};
    endcase
    prod_d = ProdW'($signed(op_a)) * ProdW'($signed(chunk));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q       <= prod_d;
      prod_shift_q <= cmd_i.mul_chunk;
    end
  end

  // Accumulator: add the product at its slice weight
  logic [AccW-1:0] prod_ext, acc_term;
  assign prod_ext = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};

  always_comb begin
    unique case (prod_shift_q)
      2'd0:    acc_term = prod_ext;
      2'd1:    acc_term = {prod_ext[AccW-17:0], 16'd0};
      default: acc_term = {prod_ext[AccW-33:0], 32'd0};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + acc_term;
    end
  end

  // Input capture and error: err = goal + count*scale
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cnt_l_q <= count_left_i;
      cnt_r_q <= count_right_i;
    end
    if (cmd_i.err_en) begin
      err_q <= {goal_w[WordW-1], goal_w} + {prod_q[WordW-1], prod_q[WordW-1:0]};
    end
    if (cmd_i.upd_en) begin
      deriv_q <= {err_q[ErrW-1], err_q} - {prior_q[w][ErrW-1], prior_q[w]};
    end
  end

  // Integral, prior error and odometry state
  logic [WideW:0]     integ_sum;
  logic [CountW:0]    cnt_sum, cnt_adj;
  logic [CountW-1:0]  half;
  logic [WideW:0]     dist_sum;

  assign integ_sum = {integ_q[w][WideW-1], integ_q[w]}
                   + {{(WideW-ErrW+1){err_q[ErrW-1]}}, err_q};
  // mean of the two counts, truncated toward zero
  assign cnt_sum  = {cnt_l_q[CountW-1], cnt_l_q} + {cnt_r_q[CountW-1], cnt_r_q};
  assign cnt_adj  = cnt_sum + {{CountW{1'b0}}, cnt_sum[CountW]};
  assign half     = cnt_adj[CountW:1];
  assign dist_sum = {dist_q[WideW-1], dist_q}
                  - {{(WideW-CountW+1){half[CountW-1]}}, half};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q[0] <= '0;
      integ_q[1] <= '0;
      prior_q[0] <= '0;
      prior_q[1] <= '0;
      dist_q     <= '0;
    end else begin
      if (cmd_i.upd_en) begin
        integ_q[w] <= sat48(integ_sum);
        prior_q[w] <= err_q;
      end
      if (cmd_i.done_en) begin
        dist_q <= sat48(dist_sum);
      end
    end
  end

  // Clamp: op = acc >>> 16 limited to +/- out_limit
  logic [AccW-17:0] s;
  logic [AccW-17:0] lim_x, neg_sum;
  logic             over_pos, over_neg;
  logic [LimW-1:0]  s_neg, mag_d;
  logic [DirW-1:0]  dir_d;

  assign s        = acc_q[AccW-1:16];
  assign lim_x    = {{(AccW-16-LimW){1'b0}}, out_limit_q};
  assign neg_sum  = s + lim_x;
  assign over_pos = !s[AccW-17] && (s > lim_x);
  assign over_neg = s[AccW-17] && neg_sum[AccW-17];
  assign s_neg    = ~s[LimW-1:0] + 31'd1;

  always_comb begin
    if (over_pos || over_neg) begin
      mag_d = out_limit_q;
    end else if (s[AccW-17]) begin
      mag_d = s_neg;
    end else begin
      mag_d = s[LimW-1:0];
    end
    if (mag_d == '0) begin
      dir_d = DIR_BRAKE;
    end else if (s[AccW-17]) begin
      dir_d = DIR_REV;
    end else begin
      dir_d = DIR_FWD;
    end
  end

  // PWM compare: ((mag*period) >> 16) - 1, floored at 0, saturated
  logic [LimW-1:0] cmp_raw;
  logic [CmpW-1:0] cmp_d;
  assign cmp_raw = prod_q[46:16];

  always_comb begin
    if (cmp_raw == '0) begin
      cmp_d = '0;
    end else if (cmp_raw > 31'd65536) begin
      cmp_d = '1;
    end else begin
      cmp_d = CmpW'(cmp_raw - 31'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clamp_en) begin
      mag_q      <= mag_d;
      dir_w_q[w] <= dir_d;
    end
    if (cmd_i.cmp_en) begin
      cmp_w_q[w] <= cmp_d;
    end
    if (cmd_i.done_en) begin
      dir_l_out_q <= dir_w_q[0];
      dir_r_out_q <= dir_w_q[1];
      cmp_l_out_q <= cmp_w_q[0];
      cmp_r_out_q <= cmp_w_q[1];
    end
  end

  assign dir_left_o      = dir_l_out_q;
  assign dir_right_o     = dir_r_out_q;
  assign compare_left_o  = cmp_l_out_q;
  assign compare_right_o = cmp_r_out_q;
  assign odometry_o      = dist_q;

endmodule

// ===== src/dual_wheel_speed_pid.sv =====
// Top level of the dual wheel speed PID controller.
// Items are processed one at a time: in_ready_o is high only in the idle state. Each wheel
// takes eleven products through the single shared 32x17 multiplier (speed, nine PID
// slices, PWM scaling).
// Reset (rst_ni low, asynchronous): registers return to their defaults,
// integrals, prior errors and odometry clear, no result is pending.
module dual_wheel_speed_pid (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dwsp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dwsp_pkg::WordW-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [15:0]          count_left_i,
  input  logic signed [15:0]          count_right_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  dir_left_o,
  output logic [15:0]                 compare_left_o,
  output logic [1:0]                  dir_right_o,
  output logic [15:0]                 compare_right_o,
  output logic signed [47:0]          odometry_o
);
  import dwsp_pkg::*;

  dwsp_cmd_t cmd;

  // Config writes complete in the cycle they are offered
  assign cfg_ready_o = 1'b1;

  dwsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  dwsp_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .count_left_i    (count_left_i),
    .count_right_i   (count_right_i),
    .dir_left_o      (dir_left_o),
    .compare_left_o  (compare_left_o),
    .dir_right_o     (dir_right_o),
    .compare_right_o (compare_right_o),
    .odometry_o      (odometry_o)
  );

endmodule

// ===== src/dwsp_checker.sv =====
// Port-level checks for the dual wheel speed PID, bound to the top level.
module dwsp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [1:0]                  dir_left_o,
  input logic [15:0]                 compare_left_o,
  input logic [1:0]                  dir_right_o,
  input logic [15:0]                 compare_right_o,
  input logic signed [47:0]          odometry_o
);
  import dwsp_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(odometry_o)
      && $stable(compare_left_o) && $stable(compare_right_o))
    else $error("result changed while stalled");

  // One item at a time: input closes after a transfer
  a_in_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input still open after transfer");

  // A new result is produced only while the input is closed
  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without work in progress");

  // Brake means a zero compare on both wheels
  a_brake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (dir_left_o != DIR_BRAKE || compare_left_o == 16'd0)
      && (dir_right_o != DIR_BRAKE || compare_right_o == 16'd0))
    else $error("nonzero compare with brake");

endmodule

bind dual_wheel_speed_pid dwsp_checker u_dwsp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .dir_left_o      (dir_left_o),
  .compare_left_o  (compare_left_o),
  .dir_right_o     (dir_right_o),
  .compare_right_o (compare_right_o),
  .odometry_o      (odometry_o)
);
